[sv/ccg_pkg.sv]
// Shared types, constants and codes for the core count governor.
package ccg_pkg;

   localparam int CORES      = 4;
   localparam int MASK_W     = 4;
   localparam int LOAD_W     = 7;
   localparam int CNT_W      = 3;
   localparam int HOLD_W     = 6;
   localparam int TYPE_W     = 2;
   localparam int ACT_W      = 2;
   localparam int IDX_W      = 2;
   localparam int ITER_W     = 3;
   localparam int SUM_W      = LOAD_W + 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // floor(x / 3) == (x * 171) >> 9 for x < 512
   localparam int RECIP3       = 171;
   localparam int RECIP3_SHIFT = 9;
   localparam int PROD_W       = SUM_W + 8;

   localparam logic [TYPE_W-1:0] REQ_TICK    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_SUSPEND = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESUME  = 2'd2;

   localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_UP   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_DOWN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CORES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREENOFF  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_HOLD  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UP_HOLD    = 3'd6;

   localparam logic [LOAD_W-1:0] RST_THRESHOLD  = 7'd80;
   localparam logic [CNT_W-1:0]  RST_MIN_CORES  = 3'd2;
   localparam logic [CNT_W-1:0]  RST_CORE_LIMIT = 3'd4;
   localparam logic [CNT_W-1:0]  RST_SCREENOFF  = 3'd2;
   localparam logic [HOLD_W-1:0] RST_DOWN_HOLD  = 6'd6;
   localparam logic [HOLD_W-1:0] RST_UP_HOLD    = 6'd2;

   typedef struct packed {
      logic              enabled;
      logic [LOAD_W-1:0] load_threshold;
      logic [CNT_W-1:0]  min_cores;
      logic [CNT_W-1:0]  core_limit;
      logic [CNT_W-1:0]  screenoff_cores;
      logic [HOLD_W-1:0] down_hold_ticks;
      logic [HOLD_W-1:0] up_hold_ticks;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SUM,
      ST_DIVIDE,
      ST_DECIDE,
      ST_SHED,
      ST_RAISE,
      ST_PUBLISH
   } state_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_START,
      OP_SUM,
      OP_DIVIDE,
      OP_DECIDE,
      OP_LOWER,
      OP_RAISE,
      OP_SUSPEND,
      OP_RESUME,
      OP_PUBLISH
   } op_type;

   typedef struct packed {
      logic ignore;
      logic is_tick;
      logic is_suspend;
      logic shed_more;
      logic raise_more;
   } dp_status_type;

endpackage

[sv/cpu_core_count_governor.sv]
// Core count governor top level: config registers, controller and datapath.
//
// Usage:
//   req_* : one transaction per tick (per-core load percents), suspend or resume
//           event. req_ready is high only while the block is idle.
//   rsp_* : exactly one result transaction per request: new online mask and
//           count, tick average, action taken and last core switched.
//   csr_* : register writes, always ready; write only while the block is idle.
// Sequence from accept to rsp_valid: ignored items go from dispatch straight to
//   publish; a tick passes sum, divide and decide; suspend and resume run a
//   shed/raise loop of one core per cycle (at most CORES steps). One item is in
//   work at a time; the next is taken the cycle after its result is loaded.
// The result sits in an output register; a stalled receiver holds it there and
//   the block keeps it until rsp_ready, only then loading the next one.
// Reset (synchronous): all cores online, hold counters zero, not suspended,
//   registers at their defaults with the governor disabled.
module cpu_core_count_governor import ccg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [TYPE_W-1:0]     req_type,
   input  logic [LOAD_W-1:0]     req_load_core0,
   input  logic [LOAD_W-1:0]     req_load_core1,
   input  logic [LOAD_W-1:0]     req_load_core2,
   input  logic [LOAD_W-1:0]     req_load_core3,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [MASK_W-1:0]     rsp_online_mask,
   output logic [CNT_W-1:0]      rsp_online_count,
   output logic [LOAD_W-1:0]     rsp_average_load,
   output logic [ACT_W-1:0]      rsp_action,
   output logic [IDX_W-1:0]      rsp_last_core_changed,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type       cfg;
   dp_status_type status;
   op_type        op;

   ccg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ccg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   ccg_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .op                    (op),
      .cfg                   (cfg),
      .req_type              (req_type),
      .req_load_core0        (req_load_core0),
      .req_load_core1        (req_load_core1),
      .req_load_core2        (req_load_core2),
      .req_load_core3        (req_load_core3),
      .status                (status),
      .rsp_online_mask       (rsp_online_mask),
      .rsp_online_count      (rsp_online_count),
      .rsp_average_load      (rsp_average_load),
      .rsp_action            (rsp_action),
      .rsp_last_core_changed (rsp_last_core_changed)
   );

endmodule

[sv/ccg_csr.sv]
// Configuration register file of the core count governor.
module ccg_csr import ccg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLED:    cfg_in.enabled         = csr_wdata[0];
            CSR_THRESHOLD:  cfg_in.load_threshold  = csr_wdata[LOAD_W-1:0];
            CSR_MIN_CORES:  cfg_in.min_cores       = csr_wdata[CNT_W-1:0];
            CSR_CORE_LIMIT: cfg_in.core_limit      = csr_wdata[CNT_W-1:0];
            CSR_SCREENOFF:  cfg_in.screenoff_cores = csr_wdata[CNT_W-1:0];
            CSR_DOWN_HOLD:  cfg_in.down_hold_ticks = csr_wdata[HOLD_W-1:0];
            CSR_UP_HOLD:    cfg_in.up_hold_ticks   = csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled         <= 1'b0;
         cfg_ff.load_threshold  <= RST_THRESHOLD;
         cfg_ff.min_cores       <= RST_MIN_CORES;
         cfg_ff.core_limit      <= RST_CORE_LIMIT;
         cfg_ff.screenoff_cores <= RST_SCREENOFF;
         cfg_ff.down_hold_ticks <= RST_DOWN_HOLD;
         cfg_ff.up_hold_ticks   <= RST_UP_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/ccg_datapath.sv]
// Datapath: core set, hold counters, load sum, average and result register.
module ccg_datapath import ccg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  op_type            op,
   input  cfg_type           cfg,
   input  logic [TYPE_W-1:0] req_type,
   input  logic [LOAD_W-1:0] req_load_core0,
   input  logic [LOAD_W-1:0] req_load_core1,
   input  logic [LOAD_W-1:0] req_load_core2,
   input  logic [LOAD_W-1:0] req_load_core3,
   output dp_status_type     status,
   output logic [MASK_W-1:0] rsp_online_mask,
   output logic [CNT_W-1:0]  rsp_online_count,
   output logic [LOAD_W-1:0] rsp_average_load,
   output logic [ACT_W-1:0]  rsp_action,
   output logic [IDX_W-1:0]  rsp_last_core_changed
);

   function automatic logic [CNT_W-1:0] count_bits(input logic [MASK_W-1:0] b);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < CORES; i++) n = n + CNT_W'(b[i]);
      return n;
   endfunction

   logic [4*LOAD_W-1:0] req_loads;

   logic [TYPE_W-1:0] type_ff, type_in;
   logic [LOAD_W-1:0] load_ff [CORES];
   logic [LOAD_W-1:0] load_in [CORES];
   logic [MASK_W-1:0] core_bits_ff, core_bits_in;
   logic [HOLD_W-1:0] up_hold_ff, up_hold_in;
   logic [HOLD_W-1:0] down_hold_ff, down_hold_in;
   logic              susp_ff, susp_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [LOAD_W-1:0] avg_ff, avg_in;
   logic [ACT_W-1:0]  action_ff, action_in;
   logic [IDX_W-1:0]  last_ff, last_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              stop_ff, stop_in;
   logic [MASK_W-1:0] out_mask_ff, out_mask_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;
   logic [LOAD_W-1:0] out_avg_ff, out_avg_in;
   logic [ACT_W-1:0]  out_action_ff, out_action_in;
   logic [IDX_W-1:0]  out_last_ff, out_last_in;

   logic [CNT_W-1:0]  cur_count;
   logic              raise_hit, lower_hit, raise_can, lower_can;
   logic [IDX_W-1:0]  raise_idx, lower_idx;
   logic [MASK_W-1:0] raised_bits, lowered_bits;
   logic [CNT_W-1:0]  shed_target, raise_target;
   logic [SUM_W-1:0]  sum_online;
   logic [PROD_W-1:0] prod3;
   logic [LOAD_W-1:0] quotient;
   logic              up_cond, down_cond;

   assign req_loads = {req_load_core3, req_load_core2, req_load_core1, req_load_core0};

   always_comb begin
      cur_count = count_bits(core_bits_ff);
      raise_hit = 1'b0;
      raise_idx = '0;
      for (int i = CORES - 1; i >= 0; i--) begin
         if (!core_bits_ff[i]) begin
            raise_hit = 1'b1;
            raise_idx = IDX_W'(i);
         end
      end
      lower_hit = 1'b0;
      lower_idx = '0;
      for (int i = 1; i < CORES; i++) begin
         if (core_bits_ff[i]) begin
            lower_hit = 1'b1;
            lower_idx = IDX_W'(i);
         end
      end
      raise_can    = (cur_count < cfg.core_limit) && raise_hit;
      lower_can    = (cur_count > cfg.min_cores) && lower_hit;
      raised_bits  = core_bits_ff | (MASK_W'(1) << raise_idx);
      lowered_bits = core_bits_ff & ~(MASK_W'(1) << lower_idx);
      shed_target  = (cfg.screenoff_cores > cfg.min_cores) ? cfg.screenoff_cores
                                                           : cfg.min_cores;
      raise_target = (cfg.core_limit < CNT_W'(CORES)) ? cfg.core_limit : CNT_W'(CORES);

      sum_online = '0;
      for (int i = 0; i < CORES; i++) begin
         if (core_bits_ff[i]) sum_online = sum_online + SUM_W'(load_ff[i]);
      end

      prod3 = PROD_W'(sum_ff) * PROD_W'(RECIP3);
      case (n_ff)
         3'd1:    quotient = LOAD_W'(sum_ff);
         3'd2:    quotient = LOAD_W'(sum_ff >> 1);
         3'd3:    quotient = LOAD_W'(prod3 >> RECIP3_SHIFT);
         3'd4:    quotient = LOAD_W'(sum_ff >> 2);
         default: quotient = '0;
      endcase

      up_cond   = ((avg_ff >= cfg.load_threshold) && (up_hold_ff >= cfg.up_hold_ticks))
                  || (n_ff < cfg.min_cores);
      down_cond = ((down_hold_ff >= cfg.down_hold_ticks) && (avg_ff <= cfg.load_threshold))
                  || (n_ff > cfg.core_limit);
   end

   always_comb begin
      status.ignore     = !cfg.enabled || (type_ff == REQ_TICK && susp_ff)
                          || (type_ff != REQ_TICK && type_ff != REQ_SUSPEND
                              && type_ff != REQ_RESUME);
      status.is_tick    = (type_ff == REQ_TICK);
      status.is_suspend = (type_ff == REQ_SUSPEND);
      status.shed_more  = (iter_ff < ITER_W'(CORES)) && (cur_count > shed_target) && !stop_ff;
      status.raise_more = (iter_ff < ITER_W'(CORES)) && (cur_count < raise_target) && !stop_ff;
   end

   always_comb begin
      type_in       = type_ff;
      load_in       = load_ff;
      core_bits_in  = core_bits_ff;
      up_hold_in    = up_hold_ff;
      down_hold_in  = down_hold_ff;
      susp_in       = susp_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      avg_in        = avg_ff;
      action_in     = action_ff;
      last_in       = last_ff;
      iter_in       = iter_ff;
      stop_in       = stop_ff;
      out_mask_in   = out_mask_ff;
      out_count_in  = out_count_ff;
      out_avg_in    = out_avg_ff;
      out_action_in = out_action_ff;
      out_last_in   = out_last_ff;
      case (op)
         OP_START: begin
            type_in = req_type;
            for (int i = 0; i < CORES; i++) load_in[i] = req_loads[i*LOAD_W +: LOAD_W];
            avg_in    = '0;
            action_in = ACT_NONE;
            last_in   = '0;
            iter_in   = '0;
            stop_in   = 1'b0;
         end
         OP_SUM: begin
            if (down_hold_ff < cfg.down_hold_ticks) down_hold_in = down_hold_ff + HOLD_W'(1);
            if (up_hold_ff < cfg.up_hold_ticks) up_hold_in = up_hold_ff + HOLD_W'(1);
            sum_in = sum_online;
            n_in   = cur_count;
         end
         OP_DIVIDE: avg_in = quotient;
         OP_DECIDE: begin
            if (up_cond) begin
               up_hold_in   = '0;
               down_hold_in = '0;
               if (raise_can) begin
                  core_bits_in = raised_bits;
                  action_in    = ACT_UP;
                  last_in      = raise_idx;
               end
            end else if (down_cond) begin
               up_hold_in   = '0;
               down_hold_in = '0;
               if (lower_can) begin
                  core_bits_in = lowered_bits;
                  action_in    = ACT_DOWN;
                  last_in      = lower_idx;
               end
            end
         end
         OP_LOWER: begin
            up_hold_in   = '0;
            down_hold_in = '0;
            iter_in      = iter_ff + ITER_W'(1);
            if (lower_can) begin
               core_bits_in = lowered_bits;
               action_in    = ACT_DOWN;
               last_in      = lower_idx;
            end else begin
               stop_in = 1'b1;
            end
         end
         OP_RAISE: begin
            up_hold_in   = '0;
            down_hold_in = '0;
            iter_in      = iter_ff + ITER_W'(1);
            if (raise_can) begin
               core_bits_in = raised_bits;
               action_in    = ACT_UP;
               last_in      = raise_idx;
            end else begin
               stop_in = 1'b1;
            end
         end
         OP_SUSPEND: susp_in = 1'b1;
         OP_RESUME:  susp_in = 1'b0;
         OP_PUBLISH: begin
            out_mask_in   = core_bits_ff;
            out_count_in  = cur_count;
            out_avg_in    = avg_ff;
            out_action_in = action_ff;
            out_last_in   = last_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         core_bits_ff <= MASK_W'((1 << CORES) - 1);
         up_hold_ff   <= '0;
         down_hold_ff <= '0;
         susp_ff      <= 1'b0;
         iter_ff      <= '0;
         stop_ff      <= 1'b0;
      end else begin
         core_bits_ff <= core_bits_in;
         up_hold_ff   <= up_hold_in;
         down_hold_ff <= down_hold_in;
         susp_ff      <= susp_in;
         iter_ff      <= iter_in;
         stop_ff      <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      load_ff       <= load_in;
      sum_ff        <= sum_in;
      n_ff          <= n_in;
      avg_ff        <= avg_in;
      action_ff     <= action_in;
      last_ff       <= last_in;
      out_mask_ff   <= out_mask_in;
      out_count_ff  <= out_count_in;
      out_avg_ff    <= out_avg_in;
      out_action_ff <= out_action_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_online_mask       = out_mask_ff;
   assign rsp_online_count      = out_count_ff;
   assign rsp_average_load      = out_avg_ff;
   assign rsp_action            = out_action_ff;
   assign rsp_last_core_changed = out_last_ff;

   a_core0_online: assert property (@(posedge clock) disable iff (reset)
      core_bits_ff[0])
      else $error("core 0 went offline");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_W'(CORES))
      else $error("shed/raise loop ran past core count");

   a_one_core_per_step: assert property (@(posedge clock) disable iff (reset)
      $countones(core_bits_in ^ core_bits_ff) <= 1)
      else $error("more than one core switched in one step");

endmodule

[sv/ccg_ctrl.sv]
// Controller state machine sequencing the governor datapath.
module ccg_ctrl import ccg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output op_type        op
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (status.ignore)          state_in = ST_PUBLISH;
            else if (status.is_tick)    state_in = ST_SUM;
            else if (status.is_suspend) state_in = ST_SHED;
            else                        state_in = ST_RAISE;
         end
         ST_SUM:      state_in = ST_DIVIDE;
         ST_DIVIDE:   state_in = ST_DECIDE;
         ST_DECIDE:   state_in = ST_PUBLISH;
         ST_SHED:     if (!status.shed_more) state_in = ST_PUBLISH;
         ST_RAISE:    if (!status.raise_more) state_in = ST_PUBLISH;
         ST_PUBLISH:  if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      op        = OP_NOP;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) op = OP_START;
         end
         ST_SUM:     op = OP_SUM;
         ST_DIVIDE:  op = OP_DIVIDE;
         ST_DECIDE:  op = OP_DECIDE;
         ST_SHED:    op = status.shed_more ? OP_LOWER : OP_SUSPEND;
         ST_RAISE:   op = status.raise_more ? OP_RAISE : OP_RESUME;
         ST_PUBLISH: if (out_free) op = OP_PUBLISH;
         default:    op = OP_NOP;
      endcase
   end

   always_comb begin
      if (op == OP_PUBLISH) rsp_valid_in = 1'b1;
      else if (rsp_ready)   rsp_valid_in = 1'b0;
      else                  rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      op == OP_PUBLISH |-> out_free)
      else $error("result register overwritten before taken");

   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      op == OP_PUBLISH |=> rsp_valid_ff)
      else $error("published result not presented");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the core count governor: random ticks and events.
`timescale 1ns / 1ps

module testbench;
   import ccg_pkg::*;

   localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTINGS_RUN = 9;

   typedef struct packed {
      logic [TYPE_W-1:0]             kind;
      logic [CORES-1:0][LOAD_W-1:0]  load;
   } core_request_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [CNT_W-1:0]  count;
      logic [LOAD_W-1:0] average;
      logic [ACT_W-1:0]  action;
      logic [IDX_W-1:0]  last_core;
   } core_decision_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [TYPE_W-1:0]     req_type = '0;
   logic [LOAD_W-1:0]     req_load_core0 = '0;
   logic [LOAD_W-1:0]     req_load_core1 = '0;
   logic [LOAD_W-1:0]     req_load_core2 = '0;
   logic [LOAD_W-1:0]     req_load_core3 = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [MASK_W-1:0]     rsp_online_mask;
   logic [CNT_W-1:0]      rsp_online_count;
   logic [LOAD_W-1:0]     rsp_average_load;
   logic [ACT_W-1:0]      rsp_action;
   logic [IDX_W-1:0]      rsp_last_core_changed;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cpu_core_count_governor u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_load_core0        (req_load_core0),
      .req_load_core1        (req_load_core1),
      .req_load_core2        (req_load_core2),
      .req_load_core3        (req_load_core3),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_online_mask       (rsp_online_mask),
      .rsp_online_count      (rsp_online_count),
      .rsp_average_load      (rsp_average_load),
      .rsp_action            (rsp_action),
      .rsp_last_core_changed (rsp_last_core_changed),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // governor shadow state and register copy
   cfg_type           gov_cfg;
   logic [MASK_W-1:0] gov_online;
   logic [HOLD_W-1:0] gov_up_hold;
   logic [HOLD_W-1:0] gov_down_hold;
   logic              gov_suspended;

   core_request_type  pending_requests[$];
   core_decision_type expected_results[$];
   core_request_type  offered_request;
   core_decision_type wanted;

   int items_queued = 0;
   int accepted_count = 0;
   int results_seen = 0;
   int fail_count = 0;
   int raises_seen = 0;
   int sheds_seen = 0;
   int hold_off = 0;
   int cycle_count = 0;

   function automatic int online_total(logic [MASK_W-1:0] m);
      int n;
      int i;
      n = 0;
      for (i = 0; i < CORES; i++) n += int'(m[i]);
      return n;
   endfunction

   function automatic int raise_core();
      int i;
      int got;
      got = -1;
      if (online_total(gov_online) < int'(gov_cfg.core_limit)) begin
         for (i = 0; i < CORES; i++) begin
            if (!gov_online[i]) begin
               gov_online[i] = 1'b1;
               got = i;
               break;
            end
         end
      end
      gov_up_hold = '0;
      gov_down_hold = '0;
      return got;
   endfunction

   function automatic int lower_core();
      int i;
      int got;
      got = -1;
      if (online_total(gov_online) > int'(gov_cfg.min_cores)) begin
         for (i = CORES - 1; i > 0; i--) begin
            if (gov_online[i]) begin
               gov_online[i] = 1'b0;
               got = i;
               break;
            end
         end
      end
      gov_up_hold = '0;
      gov_down_hold = '0;
      return got;
   endfunction

   function automatic core_decision_type predict_decision(core_request_type rq);
      core_decision_type d;
      int n;
      int sum;
      int avg;
      int target;
      int i;
      int got;
      d = '0;
      avg = 0;
      if (gov_cfg.enabled) begin
         if (rq.kind == REQ_TICK && !gov_suspended) begin
            n = online_total(gov_online);
            if (gov_down_hold < gov_cfg.down_hold_ticks)
               gov_down_hold = gov_down_hold + HOLD_W'(1);
            if (gov_up_hold < gov_cfg.up_hold_ticks) gov_up_hold = gov_up_hold + HOLD_W'(1);
            sum = 0;
            for (i = 0; i < CORES; i++) begin
               if (gov_online[i]) sum += int'(rq.load[i]);
            end
            avg = (n != 0) ? sum / n : 0;
            if ((avg >= int'(gov_cfg.load_threshold) &&
                 gov_up_hold >= gov_cfg.up_hold_ticks) ||
                n < int'(gov_cfg.min_cores)) begin
               got = raise_core();
               if (got >= 0) begin
                  d.action = ACT_UP;
                  d.last_core = got[IDX_W-1:0];
               end
            end else if ((gov_down_hold >= gov_cfg.down_hold_ticks &&
                          avg <= int'(gov_cfg.load_threshold)) ||
                         n > int'(gov_cfg.core_limit)) begin
               got = lower_core();
               if (got >= 0) begin
                  d.action = ACT_DOWN;
                  d.last_core = got[IDX_W-1:0];
               end
            end
         end else if (rq.kind == REQ_SUSPEND) begin
            target = (gov_cfg.screenoff_cores > gov_cfg.min_cores) ?
                     int'(gov_cfg.screenoff_cores) : int'(gov_cfg.min_cores);
            for (i = 0; i < CORES && online_total(gov_online) > target; i++) begin
               got = lower_core();
               if (got < 0) break;
               d.action = ACT_DOWN;
               d.last_core = got[IDX_W-1:0];
            end
            gov_suspended = 1'b1;
         end else if (rq.kind == REQ_RESUME) begin
            target = (int'(gov_cfg.core_limit) < CORES) ? int'(gov_cfg.core_limit) : CORES;
            for (i = 0; i < CORES && online_total(gov_online) < target; i++) begin
               got = raise_core();
               if (got < 0) break;
               d.action = ACT_UP;
               d.last_core = got[IDX_W-1:0];
            end
            gov_suspended = 1'b0;
         end
      end
      d.mask = gov_online;
      d.count = CNT_W'(online_total(gov_online));
      d.average = avg[LOAD_W-1:0];
      return d;
   endfunction

   function automatic void push_tick(int lo, int hi);
      core_request_type rq;
      int i;
      rq.kind = REQ_TICK;
      for (i = 0; i < CORES; i++) rq.load[i] = LOAD_W'($urandom_range(lo, hi));
      pending_requests.push_back(rq);
      items_queued++;
   endfunction

   function automatic void push_event(logic [TYPE_W-1:0] kind);
      core_request_type rq;
      int i;
      rq.kind = kind;
      for (i = 0; i < CORES; i++) rq.load[i] = LOAD_W'($urandom_range(0, 100));
      pending_requests.push_back(rq);
      items_queued++;
   endfunction

   function automatic cfg_type phase_setting(int p);
      cfg_type c;
      c.enabled = 1'b1;
      c.load_threshold = LOAD_W'($urandom_range(1, 100));
      c.min_cores = CNT_W'($urandom_range(1, 4));
      c.core_limit = CNT_W'($urandom_range(1, 4));
      c.screenoff_cores = CNT_W'($urandom_range(1, 4));
      c.down_hold_ticks = HOLD_W'(($urandom_range(0, 9) == 0) ? 50 : $urandom_range(1, 8));
      c.up_hold_ticks = HOLD_W'(($urandom_range(0, 9) == 0) ? 50 : $urandom_range(1, 8));
      case (p)
         0: begin
            c.load_threshold = 1;
            c.min_cores = 1;
            c.core_limit = 4;
            c.screenoff_cores = 1;
            c.down_hold_ticks = 1;
            c.up_hold_ticks = 1;
         end
         1: begin
            c.load_threshold = 100;
            c.min_cores = 4;
            c.core_limit = 4;
            c.screenoff_cores = 4;
            c.down_hold_ticks = 50;
            c.up_hold_ticks = 50;
         end
         2: begin
            c.min_cores = 1;
            c.core_limit = 1;
            c.screenoff_cores = 4;
            c.down_hold_ticks = 1;
            c.up_hold_ticks = 50;
         end
         3: begin
            c.min_cores = 4;
            c.core_limit = 1;
            c.down_hold_ticks = 2;
            c.up_hold_ticks = 2;
         end
         4: c.enabled = 1'b0;
         default: ;
      endcase
      return c;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ENABLED:    gov_cfg.enabled = data[0];
         CSR_THRESHOLD:  gov_cfg.load_threshold = data[LOAD_W-1:0];
         CSR_MIN_CORES:  gov_cfg.min_cores = data[CNT_W-1:0];
         CSR_CORE_LIMIT: gov_cfg.core_limit = data[CNT_W-1:0];
         CSR_SCREENOFF:  gov_cfg.screenoff_cores = data[CNT_W-1:0];
         CSR_DOWN_HOLD:  gov_cfg.down_hold_ticks = data[HOLD_W-1:0];
         CSR_UP_HOLD:    gov_cfg.up_hold_ticks = data[HOLD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_governor(cfg_type c);
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(c.load_threshold));
      write_reg(CSR_MIN_CORES, CSR_DATA_W'(c.min_cores));
      write_reg(CSR_CORE_LIMIT, CSR_DATA_W'(c.core_limit));
      write_reg(CSR_SCREENOFF, CSR_DATA_W'(c.screenoff_cores));
      write_reg(CSR_DOWN_HOLD, CSR_DATA_W'(c.down_hold_ticks));
      write_reg(CSR_UP_HOLD, CSR_DATA_W'(c.up_hold_ticks));
      write_reg(CSR_ENABLED, CSR_DATA_W'(c.enabled));
   endtask

   task automatic wait_idle();
      while (results_seen < items_queued) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // load bursts relative to the threshold so the hold counters actually expire
   task automatic fill_phase(int count);
      int n;
      int len;
      int pick;
      int thr;
      n = 0;
      thr = int'(gov_cfg.load_threshold);
      while (n < count) begin
         pick = $urandom_range(0, 99);
         len = 1;
         if (pick < 38) begin
            len = $urandom_range(2, 12);
            repeat (len) push_tick(thr, 100);
         end else if (pick < 68) begin
            len = $urandom_range(2, 12);
            repeat (len) push_tick(0, thr);
         end else if (pick < 76) begin
            len = $urandom_range(1, 4);
            repeat (len) push_tick(thr, thr);
         end else if (pick < 86) begin
            len = $urandom_range(1, 6);
            repeat (len) push_tick(0, 100);
         end else if (pick < 94) begin
            push_event(REQ_SUSPEND);
            len = $urandom_range(0, 3);
            repeat (len) push_tick(0, 100);
            push_event(REQ_RESUME);
            len = len + 2;
         end else begin
            case ($urandom_range(0, 2))
               0: push_event(REQ_SUSPEND);
               1: push_event(REQ_RESUME);
               default: push_event(REQ_UNKNOWN);
            endcase
         end
         n += len;
      end
   endtask

   task automatic check_field(string name, int exp, int act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
         fail_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_decision(offered_request));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 &&
                ((accepted_count >= 400 && accepted_count < 560) ||
                 $urandom_range(0, 99) >= 30)) begin
               offered_request = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_type <= offered_request.kind;
               req_load_core0 <= offered_request.load[0];
               req_load_core1 <= offered_request.load[1];
               req_load_core2 <= offered_request.load[2];
               req_load_core3 <= offered_request.load[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: result with nothing expected, actual mask %0d count %0d",
                        $time, rsp_online_mask, rsp_online_count);
               fail_count++;
            end else begin
               wanted = expected_results.pop_front();
               check_field("online_mask", int'(wanted.mask), int'(rsp_online_mask));
               check_field("online_count", int'(wanted.count), int'(rsp_online_count));
               check_field("average_load", int'(wanted.average), int'(rsp_average_load));
               check_field("action", int'(wanted.action), int'(rsp_action));
               check_field("last_core_changed", int'(wanted.last_core),
                           int'(rsp_last_core_changed));
            end
            if (rsp_action == ACT_UP) raises_seen++;
            if (rsp_action == ACT_DOWN) sheds_seen++;
            if (results_seen == 230 || results_seen == 800) hold_off = 160;
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (results_seen >= 420 && results_seen < 580) ||
                         ($urandom_range(0, 99) >= 30);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d of %0d results seen", $time, results_seen, items_queued);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      core_request_type rq;
      int p;
      gov_cfg.enabled = 1'b0;
      gov_cfg.load_threshold = RST_THRESHOLD;
      gov_cfg.min_cores = RST_MIN_CORES;
      gov_cfg.core_limit = RST_CORE_LIMIT;
      gov_cfg.screenoff_cores = RST_SCREENOFF;
      gov_cfg.down_hold_ticks = RST_DOWN_HOLD;
      gov_cfg.up_hold_ticks = RST_UP_HOLD;
      gov_online = '1;
      gov_up_hold = '0;
      gov_down_hold = '0;
      gov_suspended = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // disabled after reset: everything ignored
      push_tick(100, 100);
      push_event(REQ_SUSPEND);
      push_event(REQ_RESUME);
      push_event(REQ_UNKNOWN);
      wait_idle();

      // reset defaults, enabled
      write_reg(CSR_ENABLED, CSR_DATA_W'(1));
      repeat (7) push_tick(0, 0);
      repeat (4) push_tick(100, 100);
      push_event(REQ_SUSPEND);
      push_tick(100, 100);
      push_event(REQ_SUSPEND);
      push_event(REQ_RESUME);
      push_event(REQ_RESUME);
      push_event(REQ_UNKNOWN);
      push_tick(80, 80);
      rq.kind = REQ_TICK;
      rq.load = {7'd0, 7'd100, 7'd0, 7'd100};
      pending_requests.push_back(rq);
      items_queued++;
      wait_idle();

      for (p = 0; p < SETTINGS_RUN; p++) begin
         program_governor(phase_setting(p));
         fill_phase((p == 4) ? 40 : 130);
         wait_idle();
      end

      $display("Ran %0d transactions over %0d register settings with random gaps and stalls;",
               accepted_count, SETTINGS_RUN + 1);
      $display("saw %0d core raises and %0d core sheds across ticks, suspends and resumes.",
               raises_seen, sheds_seen);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
